// ===== rtl/cbts_pkg.sv =====
// ----------------------------------------------------------------------------
// cbts_pkg
// Shared constants, register indexes and polynomial coefficients for the
// bitmap-column tone synthesiser.
// ----------------------------------------------------------------------------
package cbts_pkg;

  // Defaults for the top-level parameters.
  localparam int AUDIO_RATE_DEF  = 48000;
  localparam int SINE_DEPTH_DEF  = 1024;
  localparam int TONE_COUNT_DEF  = 7;

  // Field and register widths.
  localparam int COLUMN_W   = 7;
  localparam int SAMPLE_W   = 16;
  localparam int FREQ_CFG_W = 15;
  localparam int LEN_W      = 16;
  localparam int CNT_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_LENGTH = 2'd2;

  // Input word actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Quarter-wave polynomial arithmetic.
  localparam int U_W    = 17;
  localparam int COEF_W = 31;
  localparam logic [U_W-1:0]    U_ONE    = 17'h10000;
  localparam logic [14:0]       Q15_MAX  = 15'h7fff;
  localparam logic [COEF_W-1:0] COEF1    = 31'd1686629713;
  localparam logic [COEF_W-1:0] COEF3    = 31'd693598668;
  localparam logic [COEF_W-1:0] COEF5    = 31'd85569306;
  localparam logic [COEF_W-1:0] COEF7    = 31'd5026995;
  localparam logic [COEF_W-1:0] COEF9    = 31'd172272;

  // Steps of the polynomial sequence: square, four nested terms, final product.
  localparam logic [2:0] PSTEP_SQUARE     = 3'd0;
  localparam logic [2:0] PSTEP_LAST_INNER = 3'd4;
  localparam logic [2:0] PSTEP_FINAL      = 3'd5;

  function automatic logic [COEF_W-1:0] poly_coef(input logic [2:0] step);
    logic [COEF_W-1:0] c;
    case (step)
      3'd1:    c = COEF7;
      3'd2:    c = COEF5;
      3'd3:    c = COEF3;
      default: c = COEF1;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/column_bits_tone_synth.sv =====
// ----------------------------------------------------------------------------
// column_bits_tone_synth
// Turns bitmap columns into audio: each tick of an active column gives one
// Q1.15 sample of the enabled tones, shaped by a half-sine envelope, then a silent tail.
// ----------------------------------------------------------------------------
// A tick in the tone part is worked by the one bit-serial multiplier (six products
// per sine) and the bit-serial divider (NUM_W quotient bits, NUM_W = 26 at
// defaults) for each enabled tone and for the envelope. One word is worked on at
// a time. Reset is synchronous, active low, and restores the configuration
// defaults with no column active.
module column_bits_tone_synth #(
  parameter int AUDIO_RATE       = cbts_pkg::AUDIO_RATE_DEF,
  parameter int SINE_TABLE_DEPTH = cbts_pkg::SINE_DEPTH_DEF,
  parameter int TONE_COUNT       = cbts_pkg::TONE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic [cbts_pkg::COLUMN_W-1:0]        in_column_bits,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cbts_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                 out_last_of_column,
  input  logic                                 cfg_we,
  input  logic [cbts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbts_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cbts_pkg::*;

  localparam int AW      = $clog2(SINE_TABLE_DEPTH);
  localparam int HALF    = SINE_TABLE_DEPTH / 2;
  localparam int SH      = U_W + 1 - AW;
  localparam int PH_W    = $clog2(AUDIO_RATE);
  localparam int KC      = $clog2(TONE_COUNT);
  localparam int K_W     = $clog2(TONE_COUNT + 1);
  localparam int ACC_W   = SAMPLE_W + KC;
  localparam int MAG_W   = ACC_W - 1;
  localparam int KBW_W   = FREQ_CFG_W + KC;
  localparam int ENV_R_W = LEN_W + 1;
  localparam int NI_W    = ENV_R_W + 1;
  localparam int SR_W    = $clog2(AUDIO_RATE + 1);
  localparam int DEN_W   = (SR_W > LEN_W) ? SR_W : LEN_W;
  localparam int NW_A    = PH_W + AW;
  localparam int NW_B    = (MAG_W > KBW_W) ? MAG_W : KBW_W;
  localparam int NW_C    = (NW_A > NW_B) ? NW_A : NW_B;
  localparam int NUM_W   = (NW_C > ENV_R_W) ? NW_C : ENV_R_W;
  localparam int DC_W    = $clog2(NUM_W + 1);
  localparam int PW      = COEF_W + U_W;
  localparam int MC_W    = $clog2(U_W + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LDIV = 4'd1;
  localparam logic [3:0] S_LMOD = 4'd2;
  localparam logic [3:0] S_TONE = 4'd3;
  localparam logic [3:0] S_TDIV = 4'd4;
  localparam logic [3:0] S_SIN  = 4'd5;
  localparam logic [3:0] S_PMUL = 4'd6;
  localparam logic [3:0] S_PDIV = 4'd7;
  localparam logic [3:0] S_EDIV = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]              state_r;
  logic [FREQ_CFG_W-1:0]   base_r, bw_r;
  logic [LEN_W-1:0]        len_cfg_r;
  logic [TONE_COUNT-1:0]   mask_r;
  logic [CNT_W-1:0]        count_r;
  logic                    active_r;
  logic [PH_W-1:0]         step_r  [TONE_COUNT];
  logic [PH_W-1:0]         phase_r [TONE_COUNT];
  logic [AW-1:0]           env_idx_r;
  logic [LEN_W-1:0]        env_rem_r;
  logic [K_W-1:0]          k_r;
  logic [KBW_W-1:0]        sum_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [U_W-1:0]          u_r, u2_r;
  logic                    sin_neg_r;
  logic                    sin_env_r;
  logic [2:0]              pstep_r;
  logic [SAMPLE_W-1:0]     smp_r;
  logic [PW-1:0]           mul_p_r;
  logic [COEF_W-1:0]       mul_a_r;
  logic [MC_W-1:0]         mul_cnt_r;
  logic [NUM_W-1:0]        div_num_r;
  logic [DEN_W-1:0]        div_rem_r, div_den_r;
  logic [DC_W-1:0]         div_cnt_r;
  logic [SAMPLE_W-1:0]     out_sample_r;
  logic                    out_last_r, out_valid_r;

  // Combinational helpers.
  logic [LEN_W-1:0]    len_now;
  logic [KC-1:0]       kx;
  logic [PH_W-1:0]     cur_phase, ph_next;
  logic [PH_W:0]       ph_sum;
  logic [DEN_W:0]      div_sh, div_diff;
  logic                div_ge, div_done;
  logic [NUM_W-1:0]    div_num_step;
  logic [DEN_W-1:0]    div_rem_step;
  logic [COEF_W:0]     mul_hi;
  logic [PW-1:0]       mul_p_step;
  logic                mul_done;
  logic [AW-1:0]       sin_ang;
  logic [U_W-1:0]      sin_u0, sin_u;
  logic [U_W-1:0]      p_u2, p_final;
  logic [COEF_W-1:0]   t_next;
  logic [14:0]         mag_q15;
  logic [SAMPLE_W-1:0] sin_val;
  logic [ACC_W-1:0]    acc_neg_val;
  logic [MAG_W-1:0]    acc_mag;
  logic [SAMPLE_W-1:0] quot16;
  logic [ENV_R_W-1:0]  env_r17;
  logic [NI_W-1:0]     env_ni;
  logic [CNT_W:0]      cnt_inc;
  logic                last_tick;
  logic [LEN_W-1:0]    freq_now;

  assign len_now   = (len_cfg_r == '0) ? LEN_W'(1) : len_cfg_r;
  assign kx        = k_r[KC-1:0];
  assign cur_phase = phase_r[kx];
  assign ph_sum    = {1'b0, cur_phase} + {1'b0, step_r[kx]};
  assign ph_next   = (ph_sum >= (PH_W+1)'(AUDIO_RATE)) ?
                     PH_W'(ph_sum - (PH_W+1)'(AUDIO_RATE)) : ph_sum[PH_W-1:0];

  // Restoring divider: one quotient bit per cycle, quotient shifts into num.
  assign div_sh       = {div_rem_r, div_num_r[NUM_W-1]};
  assign div_ge       = (div_sh >= {1'b0, div_den_r});
  assign div_diff     = div_sh - {1'b0, div_den_r};
  assign div_rem_step = div_ge ? div_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
  assign div_num_step = {div_num_r[NUM_W-2:0], div_ge};
  assign div_done     = (div_cnt_r == '0);

  // Shift-add multiplier: the multiplier operand leaves one bit per cycle.
  assign mul_hi     = {1'b0, mul_p_r[PW-1:U_W]} + {1'b0, mul_a_r};
  assign mul_p_step = mul_p_r[0] ? {mul_hi, mul_p_r[U_W-1:1]} : {1'b0, mul_p_r[PW-1:1]};
  assign mul_done   = (mul_cnt_r == '0);

  // Fold the angle to a quarter wave and form the Q16 fraction.
  assign sin_ang = (state_r == S_TONE) ? env_idx_r : div_num_r[AW-1:0];
  assign sin_u0  = U_W'(sin_ang[AW-3:0]) << SH;
  assign sin_u   = sin_ang[AW-2] ? (U_ONE - sin_u0) : sin_u0;

  assign p_u2    = mul_p_r[U_W+15:16];
  assign t_next  = poly_coef(pstep_r) - mul_p_r[COEF_W+15:16];
  assign p_final = mul_p_r[PW-1:COEF_W];
  assign mag_q15 = (p_final > U_W'(Q15_MAX)) ? Q15_MAX : p_final[14:0];
  assign sin_val = sin_neg_r ? (SAMPLE_W'(0) - {1'b0, mag_q15}) : {1'b0, mag_q15};

  assign acc_neg_val = ACC_W'(0) - acc_r;
  assign acc_mag     = acc_r[ACC_W-1] ? acc_neg_val[MAG_W-1:0] : acc_r[MAG_W-1:0];
  assign quot16      = {1'b0, div_num_r[14:0]};
  assign env_r17     = ENV_R_W'(env_rem_r) + ENV_R_W'(HALF);
  assign env_ni      = NI_W'(env_idx_r) + NI_W'(div_num_r[ENV_R_W-1:0]);
  assign cnt_inc     = {1'b0, count_r} + (CNT_W+1)'(1);
  assign last_tick   = (cnt_inc >= (CNT_W+1)'({len_now, 1'b0}));
  assign freq_now    = {1'b0, base_r} + {1'b0, div_num_r[FREQ_CFG_W-1:0]};

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_sample         = out_sample_r;
  assign out_last_of_column = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= FREQ_CFG_W'(1200);
      bw_r        <= FREQ_CFG_W'(1000);
      len_cfg_r   <= LEN_W'(1920);
      active_r    <= 1'b0;
      count_r     <= '0;
      mask_r      <= '0;
      mul_cnt_r   <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_FREQ:   base_r    <= cfg_data[FREQ_CFG_W-1:0];
          CFG_BANDWIDTH:   bw_r      <= cfg_data[FREQ_CFG_W-1:0];
          CFG_TONE_LENGTH: len_cfg_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Shared units step by default; a start below overrides.
      if (!mul_done) begin
        mul_p_r   <= mul_p_step;
        mul_cnt_r <= mul_cnt_r - MC_W'(1);
      end
      if (!div_done) begin
        div_num_r <= div_num_step;
        div_rem_r <= div_rem_step;
        div_cnt_r <= div_cnt_r - DC_W'(1);
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_action == ACT_LOAD) begin
              mask_r    <= TONE_COUNT'(in_column_bits);
              for (int i = 0; i < TONE_COUNT; i++) begin
                phase_r[i] <= '0;
              end
              count_r   <= '0;
              env_idx_r <= '0;
              env_rem_r <= '0;
              active_r  <= 1'b1;
              k_r       <= '0;
              sum_r     <= '0;
              div_num_r <= '0;
              div_rem_r <= '0;
              div_den_r <= DEN_W'(TONE_COUNT - 1);
              div_cnt_r <= DC_W'(NUM_W);
              state_r   <= S_LDIV;
            end else if (active_r) begin
              acc_r <= '0;
              k_r   <= '0;
              if (count_r < CNT_W'(len_now)) begin
                state_r <= S_TONE;
              end else begin
                smp_r   <= '0;
                state_r <= S_EMIT;
              end
            end
          end
        end

        S_LDIV: begin
          if (div_done) begin
            div_num_r <= NUM_W'(freq_now);
            div_rem_r <= '0;
            div_den_r <= DEN_W'(AUDIO_RATE);
            div_cnt_r <= DC_W'(NUM_W);
            state_r   <= S_LMOD;
          end
        end

        S_LMOD: begin
          if (div_done) begin
            step_r[kx] <= div_rem_r[PH_W-1:0];
            k_r        <= k_r + K_W'(1);
            sum_r      <= sum_r + KBW_W'(bw_r);
            if (k_r == K_W'(TONE_COUNT - 1)) begin
              state_r <= S_IDLE;
            end else begin
              div_num_r <= NUM_W'(sum_r + KBW_W'(bw_r));
              div_rem_r <= '0;
              div_den_r <= DEN_W'(TONE_COUNT - 1);
              div_cnt_r <= DC_W'(NUM_W);
              state_r   <= S_LDIV;
            end
          end
        end

        S_TONE: begin
          if (k_r == K_W'(TONE_COUNT)) begin
            // All tones summed: the envelope sine comes next.
            sin_env_r <= 1'b1;
            u_r       <= sin_u;
            sin_neg_r <= sin_ang[AW-1];
            pstep_r   <= PSTEP_SQUARE;
            mul_a_r   <= COEF_W'(sin_u);
            mul_p_r   <= PW'(sin_u);
            mul_cnt_r <= MC_W'(U_W);
            state_r   <= S_SIN;
          end else begin
            phase_r[kx] <= ph_next;
            k_r         <= k_r + K_W'(1);
            if (mask_r[kx]) begin
              div_num_r <= NUM_W'(cur_phase) << AW;
              div_rem_r <= '0;
              div_den_r <= DEN_W'(AUDIO_RATE);
              div_cnt_r <= DC_W'(NUM_W);
              state_r   <= S_TDIV;
            end
          end
        end

        S_TDIV: begin
          if (div_done) begin
            sin_env_r <= 1'b0;
            u_r       <= sin_u;
            sin_neg_r <= sin_ang[AW-1];
            pstep_r   <= PSTEP_SQUARE;
            mul_a_r   <= COEF_W'(sin_u);
            mul_p_r   <= PW'(sin_u);
            mul_cnt_r <= MC_W'(U_W);
            state_r   <= S_SIN;
          end
        end

        S_SIN: begin
          if (mul_done) begin
            pstep_r <= pstep_r + 3'd1;
            if (pstep_r == PSTEP_SQUARE) begin
              u2_r      <= p_u2;
              mul_a_r   <= COEF9;
              mul_p_r   <= PW'(p_u2);
              mul_cnt_r <= MC_W'(U_W);
            end else if (pstep_r != PSTEP_FINAL) begin
              mul_a_r   <= t_next;
              mul_p_r   <= (pstep_r == PSTEP_LAST_INNER) ? PW'(u_r) : PW'(u2_r);
              mul_cnt_r <= MC_W'(U_W);
            end else if (sin_env_r) begin
              // A negative envelope counts as silence.
              mul_a_r   <= COEF_W'(acc_mag);
              mul_p_r   <= sin_neg_r ? '0 : PW'(mag_q15);
              mul_cnt_r <= MC_W'(U_W);
              state_r   <= S_PMUL;
            end else begin
              acc_r   <= acc_r + ACC_W'($signed(sin_val));
              state_r <= S_TONE;
            end
          end
        end

        S_PMUL: begin
          if (mul_done) begin
            div_num_r <= NUM_W'(mul_p_r[MAG_W+14:15]);
            div_rem_r <= '0;
            div_den_r <= DEN_W'(TONE_COUNT);
            div_cnt_r <= DC_W'(NUM_W);
            state_r   <= S_PDIV;
          end
        end

        S_PDIV: begin
          if (div_done) begin
            smp_r     <= acc_r[ACC_W-1] ? (SAMPLE_W'(0) - quot16) : quot16;
            div_num_r <= NUM_W'(env_r17);
            div_rem_r <= '0;
            div_den_r <= DEN_W'(len_now);
            div_cnt_r <= DC_W'(NUM_W);
            state_r   <= S_EDIV;
          end
        end

        S_EDIV: begin
          if (div_done) begin
            env_rem_r <= div_rem_r[LEN_W-1:0];
            env_idx_r <= (env_ni > NI_W'(HALF)) ? AW'(HALF) : env_ni[AW-1:0];
            state_r   <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_sample_r <= smp_r;
            out_last_r   <= last_tick;
            out_valid_r  <= 1'b1;
            count_r      <= cnt_inc[CNT_W-1:0];
            if (last_tick) begin
              active_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for column_bits_tone_synth
// Drives load and tick words with random idling on both sides, predicts every
// sample and end-of-column flag in a local model and compares them in order.
// ----------------------------------------------------------------------------
module testbench;
  import cbts_pkg::*;

  localparam int RATE  = 48000;
  localparam int DEPTH = 1024;
  localparam int TONES = 7;
  localparam int LIMIT = 200000;

  typedef struct packed {
    logic                       action;
    logic [COLUMN_W-1:0]        bits;
    logic                       check_fixed;
    logic signed [SAMPLE_W-1:0] fixed_sample;
    logic                       fixed_last;
  } stim_row_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } audio_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [COLUMN_W-1:0] in_column_bits = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic out_last_of_column;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  column_bits_tone_synth dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_column_bits(in_column_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample(out_sample), .out_last_of_column(out_last_of_column),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state.
  logic [14:0] base_hz;
  logic [14:0] spread_hz;
  logic [15:0] column_len;
  logic [6:0]  mask_q;
  logic [16:0] tick_count;
  logic        playing;
  logic [31:0] freq_q [TONES];
  logic [31:0] phase_q [TONES];
  logic [31:0] env_idx;
  logic [31:0] env_rem;

  audio_word_t pending_samples[$];
  int mismatches = 0;
  int words_seen = 0;
  int stall_pct = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  function automatic int quarter_wave(longint unsigned u);
    longint unsigned u2, t, r;
    u2 = (u * u) >> 16;
    t = 172272;
    t = 5026995 - ((u2 * t) >> 16);
    t = 85569306 - ((u2 * t) >> 16);
    t = 693598668 - ((u2 * t) >> 16);
    t = 1686629713 - ((u2 * t) >> 16);
    r = (u * t) >> 31;
    if (r > 32767) r = 32767;
    return int'(r);
  endfunction

  function automatic int sine_of(longint unsigned angle);
    longint unsigned n, q, u;
    int m;
    n = (angle % DEPTH) * 4;
    q = n / DEPTH;
    u = ((n - q * DEPTH) << 16) / DEPTH;
    if (q[0]) u = 65536 - u;
    m = quarter_wave(u);
    return (q >= 2) ? -m : m;
  endfunction

  task automatic predict_word(input logic action, input logic [6:0] bits);
    longint unsigned len, half, r, ni, last;
    longint signed acc, smp, env;
    audio_word_t w;
    if (action == ACT_LOAD) begin
      mask_q = bits;
      for (int k = 0; k < TONES; k++) begin
        freq_q[k] = base_hz + (k * spread_hz) / (TONES - 1);
        phase_q[k] = 0;
      end
      tick_count = 0;
      env_idx = 0;
      env_rem = 0;
      playing = 1'b1;
      return;
    end
    if (!playing) return;
    len = (column_len == 0) ? 1 : column_len;
    half = DEPTH / 2;
    smp = 0;
    if (tick_count < len) begin
      acc = 0;
      for (int k = 0; k < TONES; k++)
        if (mask_q[k]) acc += sine_of((longint'(phase_q[k]) * DEPTH) / RATE);
      env = sine_of(env_idx);
      if (env < 0) env = 0;
      smp = (acc * env) / (TONES * 32768);
      for (int k = 0; k < TONES; k++)
        phase_q[k] = (phase_q[k] + freq_q[k] % RATE) % RATE;
      r = env_rem + half;
      ni = env_idx + r / len;
      env_rem = r % len;
      env_idx = (ni > half) ? half : ni;
    end
    last = (tick_count + 1 >= 2 * len) ? 1 : 0;
    tick_count = tick_count + 1;
    if (last) playing = 1'b0;
    w.sample = smp[15:0];
    w.last = last[0];
    pending_samples.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Result checker, sampling at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected word", out_sample, 0);
      end else begin
        audio_word_t w;
        w = pending_samples.pop_front();
        if (out_sample !== w.sample) report_mismatch("sample", out_sample, w.sample);
        if (out_last_of_column !== w.last)
          report_mismatch("last_of_column", out_last_of_column, w.last);
        words_seen++;
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Called at a falling edge; leaves valid high after the accepting edge so that
  // a following word can go straight out. The caller drops valid when it stops.
  task automatic send_word(input logic action, input logic [6:0] bits);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_column_bits <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(action, bits);
    @(negedge clk);
  endtask

  // Writes a register once the block has drained; a load has no result, so wait
  // out its working time too.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (4000) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_BASE_FREQ) base_hz = val[14:0];
    else if (idx == CFG_BANDWIDTH) spread_hz = val[14:0];
    else if (idx == CFG_TONE_LENGTH) column_len = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_fixed_row(input stim_row_t row);
    audio_word_t w;
    if (!row.check_fixed) return;
    if (pending_samples.size() == 0) return;
    w = pending_samples[pending_samples.size() - 1];
    if (w.sample !== row.fixed_sample || w.last !== row.fixed_last)
      report_mismatch("directed row", w.sample, row.fixed_sample);
  endtask

  stim_row_t directed [] = '{
    '{ACT_TICK, 7'h7f, 1'b0, 16'sd0, 1'b0},  // tick before any load is ignored
    '{ACT_LOAD, 7'h7f, 1'b0, 16'sd0, 1'b0},
    '{ACT_TICK, 7'h00, 1'b1, 16'sd0, 1'b0},  // envelope starts at zero
    '{ACT_TICK, 7'h00, 1'b0, 16'sd0, 1'b0},
    '{ACT_TICK, 7'h00, 1'b0, 16'sd0, 1'b0},
    '{ACT_TICK, 7'h00, 1'b1, 16'sd0, 1'b0},  // first silent tick
    '{ACT_TICK, 7'h00, 1'b0, 16'sd0, 1'b0},
    '{ACT_TICK, 7'h00, 1'b1, 16'sd0, 1'b1},  // end of column
    '{ACT_TICK, 7'h00, 1'b0, 16'sd0, 1'b0},  // ignored
    '{ACT_LOAD, 7'h00, 1'b0, 16'sd0, 1'b0},
    '{ACT_TICK, 7'h00, 1'b1, 16'sd0, 1'b0},  // no tones enabled
    '{ACT_TICK, 7'h00, 1'b1, 16'sd0, 1'b0},
    '{ACT_LOAD, 7'h01, 1'b0, 16'sd0, 1'b0},
    '{ACT_TICK, 7'h00, 1'b0, 16'sd0, 1'b0},
    '{ACT_TICK, 7'h00, 1'b0, 16'sd0, 1'b0},
    '{ACT_LOAD, 7'h40, 1'b0, 16'sd0, 1'b0},  // reload mid-column
    '{ACT_TICK, 7'h00, 1'b0, 16'sd0, 1'b0},
    '{ACT_TICK, 7'h00, 1'b0, 16'sd0, 1'b0},
    '{ACT_TICK, 7'h00, 1'b0, 16'sd0, 1'b0}
  };

  task automatic random_phase(input int words, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < words; n++) begin
      if (!playing || $urandom_range(99) < 4) begin
        send_word(ACT_LOAD, 7'($urandom));
      end else begin
        send_word(ACT_TICK, 7'($urandom));
      end
    end
  endtask

  initial begin
    base_hz = 15'd1200;
    spread_hz = 15'd1000;
    column_len = 16'd1920;
    mask_q = '0;
    tick_count = '0;
    playing = 1'b0;
    env_idx = 0;
    env_rem = 0;
    for (int k = 0; k < TONES; k++) begin
      freq_q[k] = 0;
      phase_q[k] = 0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(CFG_TONE_LENGTH, 16'd3);
    foreach (directed[i]) begin
      send_word(directed[i].action, directed[i].bits);
      check_fixed_row(directed[i]);
    end

    // Extremes: top frequencies wrap the phase step; zero length acts as one.
    write_reg(CFG_BASE_FREQ, 16'd24000);
    write_reg(CFG_BANDWIDTH, 16'd24000);
    write_reg(CFG_TONE_LENGTH, 16'd0);
    random_phase(60, 0, 0);
    write_reg(CFG_BASE_FREQ, 16'h7fff);
    write_reg(CFG_BANDWIDTH, 16'h7fff);
    write_reg(CFG_TONE_LENGTH, 16'd9);
    random_phase(200, 63, 0);
    write_reg(CFG_BASE_FREQ, 16'd0);
    write_reg(CFG_BANDWIDTH, 16'd0);
    write_reg(CFG_TONE_LENGTH, 16'd1);
    random_phase(150, 0, 63);
    write_reg(CFG_BASE_FREQ, 16'($urandom_range(24000)));
    write_reg(CFG_BANDWIDTH, 16'($urandom_range(24000)));
    write_reg(CFG_TONE_LENGTH, 16'($urandom_range(2, 40)));
    random_phase(600, 0, 0);
    write_reg(CFG_BASE_FREQ, 16'd1200);
    write_reg(CFG_BANDWIDTH, 16'd1000);
    write_reg(CFG_TONE_LENGTH, 16'd12);
    random_phase(600, 11, 11);
    // Changing the length mid-column: the shorter value applies at once.
    write_reg(CFG_TONE_LENGTH, 16'd200);
    send_word(ACT_LOAD, 7'h55);
    repeat (30) send_word(ACT_TICK, 7'h00);
    write_reg(CFG_TONE_LENGTH, 16'd5);
    random_phase(200, 63, 63);
    write_reg(CFG_TONE_LENGTH, 16'hffff);
    send_word(ACT_LOAD, 7'h7f);
    random_phase(100, 0, 0);
    in_valid <= 1'b0;

    while (pending_samples.size() != 0) @(negedge clk);
    repeat (4000) @(negedge clk);
    $display("checked %0d result words over several register settings and idling phases",
             words_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
